/* sv/reliable_udp_ack_tracker_top_assert.svh */
// Assertion macros for the ack tracker.
`ifndef RELIABLE_UDP_ACK_TRACKER_TOP_ASSERT_SVH
`define RELIABLE_UDP_ACK_TRACKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RUT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define RUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RUT_ASSERT_IMP(lbl, ante, cons, msg)
`define RUT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/rut_pkg.sv */
// Shared types, constants and helpers of the ack tracker.
`default_nettype none
package rut_pkg;

    localparam int PEND_DEPTH_DEF = 64;
    localparam int RECV_DEPTH_DEF = 64;
    localparam int RECV_SPAN_DEF  = 34;
    localparam int MAX_ACKS       = 33;
    localparam int ACK_WINDOW     = 31;
    localparam int FILL_W         = 11;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [15:0] RTT_MAX_RESET = 16'd1000;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_RECV = 2'd1,
        OP_ACK  = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic {
        REG_RTT_MAX = 1'b0,
        REG_NONE    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [31:0] seq_in;
        logic [31:0] ack_seq;
        logic [31:0] ack_bits_in;
    } in_beat_t;

    typedef struct packed {
        logic        last;
        logic        acked_valid;
        logic [31:0] acked_seq;
        logic [31:0] local_seq;
        logic [31:0] remote_seq;
        logic [31:0] ack_bits;
        logic [31:0] sent_count;
        logic [31:0] recv_count;
        logic [31:0] lost_count;
        logic [31:0] acked_count;
        logic [31:0] rtt_est;
    } out_beat_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [31:0] abits;
    } cmd_t;

    typedef struct packed {
        logic              idle;
        logic [FILL_W-1:0] pend_fill;
        logic [FILL_W-1:0] recv_fill;
    } eng_stat_t;

    // Four quotient bits of a long division by ten; returns {quotient, remainder}.
    function automatic logic [7:0] div10_step(input logic [3:0] rem, input logic [3:0] din);
        logic [4:0] r5;
        logic [3:0] r;
        logic [3:0] q;
        r = rem;
        q = 4'd0;
        for (int k = 3; k >= 0; k--)
        begin
            r5 = {r, din[k]};
            if (r5 >= 5'd10)
            begin
                r5 = r5 - 5'd10;
                q[k] = 1'b1;
            end
            r = r5[3:0];
        end
        return {q, r};
    endfunction

endpackage
`default_nettype wire

/* sv/reliable_udp_ack_tracker_top.sv */
// Top level of the reliable-UDP ack tracker.
//
//  channel  | handshake                       | payload
//  ---------+---------------------------------+---------------------------
//  command  | start / busy, beat on start&!busy | item   (rut_pkg::in_beat_t)
//  result   | done strobe, one cycle per beat | result (rut_pkg::out_beat_t)
//  config   | APB psel/penable/pwrite, pready=1 | pwdata / prdata, paddr
//
// Every store has a registered read port, so each RAM-scanned entry takes a
// read state and a check state. Send writes the pending store; receive scans
// the received store for a duplicate and then rebuilds the ack bits; ack scans
// the pending store, and each ack costs a 9-step divide by ten plus the RTT
// update and its own result beat; tick removes stale entries, then rebuilds
// the ack bits over the received entries left after pruning.
// Reset: rst_n async low clears counters, fills and pointers; store contents
// need no clearing since only entries below the fill counts are read.
// Results cannot be held off; a two-entry command queue lets start be taken
// while the engine works, busy rises only when that queue is full.
`default_nettype none
module reliable_udp_ack_tracker_top #(
    parameter int PEND_DEPTH = rut_pkg::PEND_DEPTH_DEF,
    parameter int RECV_DEPTH = rut_pkg::RECV_DEPTH_DEF,
    parameter int RECV_SPAN  = rut_pkg::RECV_SPAN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rut_pkg::in_beat_t  item,
    output logic                    done,
    output rut_pkg::out_beat_t      result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic               cmd_valid;
    rut_pkg::cmd_t      cmd;
    logic               cmd_pop;
    rut_pkg::eng_stat_t stat;
    logic [15:0]        rtt_max_reg;
    rut_pkg::reg_idx_t  reg_sel;

    // config register: only the loss threshold
    assign pready  = 1'b1;
    assign reg_sel = rut_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtt_max_reg <= rut_pkg::RTT_MAX_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel == rut_pkg::REG_RTT_MAX)
        begin
            rtt_max_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            rut_pkg::REG_RTT_MAX: prdata = {16'd0, rtt_max_reg};
            default:              prdata = '0;
        endcase
    end

    // front: take and decode the command beat
    rut_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    // back: stores, scans and result beats
    rut_engine #(
        .PEND_DEPTH(PEND_DEPTH), .RECV_DEPTH(RECV_DEPTH), .RECV_SPAN(RECV_SPAN)
    ) u_engine (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .rtt_max(rtt_max_reg), .done(done), .result(result), .stat(stat)
    );

`include "reliable_udp_ack_tracker_top_assert.svh"

    `RUT_ASSERT_IMP(a_ack_not_last, done && result.acked_valid, !result.last, "ack beat marked last")
    `RUT_ASSERT_NEXT(a_summary_alone, done && result.last, !done, "beat right after summary")
    `RUT_ASSERT_IMP(a_pend_fill, 1'b1, stat.pend_fill <= rut_pkg::FILL_W'(PEND_DEPTH), "pend overflow")
    `RUT_ASSERT_IMP(a_recv_fill, 1'b1, stat.recv_fill <= rut_pkg::FILL_W'(RECV_DEPTH), "recv overflow")
    `RUT_ASSERT_NEXT(a_pop_idle, cmd_pop, !stat.idle, "engine idle after taking a command")

endmodule
`default_nettype wire

/* sv/rut_ram.sv */
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module rut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

/* sv/rut_front.sv */
// Command intake: decode and a short queue toward the engine.
`default_nettype none
module rut_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire rut_pkg::in_beat_t item,
    output logic                   busy,
    output logic                   cmd_valid,
    output rut_pkg::cmd_t          cmd,
    input  wire logic              cmd_pop
);
    localparam int QA_W = $clog2(rut_pkg::QUEUE_DEPTH);
    localparam int QC_W = $clog2(rut_pkg::QUEUE_DEPTH + 1);

    rut_pkg::cmd_t    q_reg [rut_pkg::QUEUE_DEPTH];
    logic [QA_W-1:0]  wp_reg, wp_next;
    logic [QA_W-1:0]  rp_reg, rp_next;
    logic [QC_W-1:0]  cnt_reg, cnt_next;
    rut_pkg::cmd_t    dec;
    logic             push;
    logic             pop;

    always_comb
    begin
        dec.op     = rut_pkg::op_t'(item.action);
        dec.now_ms = item.now_ms;
        dec.seq    = item.seq_in;
        dec.ack    = item.ack_seq;
        dec.abits  = item.ack_bits_in;
    end

    assign busy      = (cnt_reg == QC_W'(rut_pkg::QUEUE_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == QA_W'(rut_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == QA_W'(rut_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= dec;
        end
    end
endmodule
`default_nettype wire

/* sv/rut_engine.sv */
// Execution engine: stores, scans, RTT filter and result emission.
`default_nettype none
module rut_engine #(
    parameter int PEND_DEPTH = rut_pkg::PEND_DEPTH_DEF,
    parameter int RECV_DEPTH = rut_pkg::RECV_DEPTH_DEF,
    parameter int RECV_SPAN  = rut_pkg::RECV_SPAN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire rut_pkg::cmd_t      cmd,
    output logic                    cmd_pop,
    input  wire logic [15:0]        rtt_max,
    output logic                    done,
    output rut_pkg::out_beat_t      result,
    output rut_pkg::eng_stat_t      stat
);
    localparam int PA_W = $clog2(PEND_DEPTH);
    localparam int PF_W = $clog2(PEND_DEPTH + 1);
    localparam int RA_W = $clog2(RECV_DEPTH);
    localparam int RF_W = $clog2(RECV_DEPTH + 1);
    localparam int AB_W = $clog2(rut_pkg::MAX_ACKS);
    localparam int AK_W = $clog2(rut_pkg::MAX_ACKS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SEND, S_DUP_RD, S_DUP_CHK, S_RECV_WR, S_ACK_RD, S_ACK_CHK,
        S_DIV, S_RTT, S_PRUNE_RD, S_PRUNE_CHK, S_EXP_RD, S_EXP_CHK,
        S_BITS_RD, S_BITS_CHK, S_EMIT_RD, S_EMIT_OUT, S_SUMMARY
    } state_t;

    function automatic logic [PA_W-1:0] p_wrap(input logic [PA_W:0] x);
        return (x >= (PA_W+1)'(PEND_DEPTH)) ? PA_W'(x - (PA_W+1)'(PEND_DEPTH)) : x[PA_W-1:0];
    endfunction

    function automatic logic [RA_W-1:0] r_wrap(input logic [RA_W:0] x);
        return (x >= (RA_W+1)'(RECV_DEPTH)) ? RA_W'(x - (RA_W+1)'(RECV_DEPTH)) : x[RA_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    rut_pkg::cmd_t      cmd_reg, cmd_next;
    logic [31:0]        local_reg, local_next;
    logic [31:0]        remote_reg, remote_next;
    logic [31:0]        latest_reg, latest_next;
    logic [31:0]        sent_reg, sent_next;
    logic [31:0]        recvc_reg, recvc_next;
    logic [31:0]        lost_reg, lost_next;
    logic [31:0]        ackc_reg, ackc_next;
    logic [31:0]        rtt_reg, rtt_next;
    logic [31:0]        bits_reg, bits_next;
    logic [PA_W-1:0]    p_head_reg, p_head_next;
    logic [PF_W-1:0]    p_fill_reg, p_fill_next;
    logic [PF_W-1:0]    p_idx_reg, p_idx_next;
    logic [PF_W-1:0]    p_wj_reg, p_wj_next;
    logic [RA_W-1:0]    r_head_reg, r_head_next;
    logic [RF_W-1:0]    r_fill_reg, r_fill_next;
    logic [RF_W-1:0]    r_idx_reg, r_idx_next;
    logic               dup_reg, dup_next;
    logic [AK_W-1:0]    nack_reg, nack_next;
    logic [AK_W-1:0]    emit_reg, emit_next;
    logic [35:0]        div_reg, div_next;
    logic [3:0]         rem_reg, rem_next;
    logic [3:0]         dcnt_reg, dcnt_next;
    logic               neg_reg, neg_next;
    logic               done_reg, done_next;
    rut_pkg::out_beat_t result_reg, result_next;

    logic               p_we;
    logic [PA_W-1:0]    p_wa, p_ra;
    logic [63:0]        p_wd, p_rd;
    logic               r_we;
    logic [RA_W-1:0]    r_wa, r_ra;
    logic [31:0]        r_wd, r_rd;
    logic               a_we;
    logic [AB_W-1:0]    a_wa, a_ra;
    logic [31:0]        a_wd, a_rd;

    logic [31:0]        p_seq, p_stamp, age, d_ack, d_bits, minseq;
    logic               hit;
    logic [36:0]        diff, diff_neg, rsum;
    logic [7:0]         dstep;

    rut_ram #(.WIDTH(64), .DEPTH(PEND_DEPTH)) u_pend_ram (
        .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd)
    );
    rut_ram #(.WIDTH(32), .DEPTH(RECV_DEPTH)) u_recv_ram (
        .clk(clk), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd), .rd_addr(r_ra), .rd_data(r_rd)
    );
    rut_ram #(.WIDTH(32), .DEPTH(rut_pkg::MAX_ACKS)) u_ack_ram (
        .clk(clk), .wr_en(a_we), .wr_addr(a_wa), .wr_data(a_wd), .rd_addr(a_ra), .rd_data(a_rd)
    );

    assign p_seq   = p_rd[63:32];
    assign p_stamp = p_rd[31:0];
    assign age     = cmd_reg.now_ms - p_stamp;
    assign d_ack   = cmd_reg.ack - 32'd1 - p_seq;
    assign d_bits  = remote_reg - 32'd1 - r_rd;
    assign minseq  = (latest_reg > 32'(RECV_SPAN)) ? latest_reg - 32'(RECV_SPAN) : 32'd0;
    assign diff     = {1'b0, age, 4'b0000} - {5'b00000, rtt_reg};
    assign diff_neg = 37'd0 - diff;
    assign rsum     = {5'b00000, rtt_reg} + {1'b0, div_reg};
    assign dstep    = rut_pkg::div10_step(rem_reg, div_reg[35:32]);

    always_comb
    begin
        if (p_seq == cmd_reg.ack)
        begin
            hit = 1'b1;
        end
        else if (p_seq < cmd_reg.ack && d_ack <= 32'(rut_pkg::ACK_WINDOW))
        begin
            hit = cmd_reg.abits[d_ack[4:0]];
        end
        else
        begin
            hit = 1'b0;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        local_next  = local_reg;
        remote_next = remote_reg;
        latest_next = latest_reg;
        sent_next   = sent_reg;
        recvc_next  = recvc_reg;
        lost_next   = lost_reg;
        ackc_next   = ackc_reg;
        rtt_next    = rtt_reg;
        bits_next   = bits_reg;
        p_head_next = p_head_reg;
        p_fill_next = p_fill_reg;
        p_idx_next  = p_idx_reg;
        p_wj_next   = p_wj_reg;
        r_head_next = r_head_reg;
        r_fill_next = r_fill_reg;
        r_idx_next  = r_idx_reg;
        dup_next    = dup_reg;
        nack_next   = nack_reg;
        emit_next   = emit_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd_pop     = 1'b0;
        p_we = 1'b0;
        p_wa = p_wrap({1'b0, p_head_reg} + (PA_W+1)'(p_fill_reg));
        p_wd = {local_reg, cmd_reg.now_ms};
        p_ra = p_wrap({1'b0, p_head_reg} + (PA_W+1)'(p_idx_reg[PA_W-1:0]));
        r_we = 1'b0;
        r_wa = r_wrap({1'b0, r_head_reg} + (RA_W+1)'(r_fill_reg));
        r_wd = cmd_reg.seq;
        r_ra = r_wrap({1'b0, r_head_reg} + (RA_W+1)'(r_idx_reg[RA_W-1:0]));
        a_we = 1'b0;
        a_wa = nack_reg[AB_W-1:0];
        a_wd = p_seq;
        a_ra = emit_reg[AB_W-1:0];

        result_next.local_seq   = local_reg;
        result_next.remote_seq  = remote_reg;
        result_next.ack_bits    = bits_reg;
        result_next.sent_count  = sent_reg;
        result_next.recv_count  = recvc_reg;
        result_next.lost_count  = lost_reg;
        result_next.acked_count = ackc_reg;
        result_next.rtt_est     = rtt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    nack_next  = '0;
                    emit_next  = '0;
                    p_idx_next = '0;
                    p_wj_next  = '0;
                    r_idx_next = '0;
                    dup_next   = 1'b0;
                    unique case (cmd.op)
                        rut_pkg::OP_SEND: state_next = S_SEND;
                        rut_pkg::OP_RECV:
                        begin
                            recvc_next = recvc_reg + 32'd1;
                            state_next = (r_fill_reg == '0) ? S_RECV_WR : S_DUP_RD;
                        end
                        rut_pkg::OP_ACK:  state_next = S_ACK_RD;
                        rut_pkg::OP_TICK: state_next = S_PRUNE_RD;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_SEND:
            begin
                p_we = 1'b1;
                if (p_fill_reg == PF_W'(PEND_DEPTH))
                begin
                    // when full, the oldest slot is the head slot; overwrite it
                    p_wa        = p_head_reg;
                    p_head_next = p_wrap({1'b0, p_head_reg} + (PA_W+1)'(1));
                    lost_next   = lost_reg + 32'd1;
                end
                else
                begin
                    p_fill_next = p_fill_reg + 1'b1;
                end
                sent_next  = sent_reg + 32'd1;
                local_next = local_reg + 32'd1;
                state_next = S_SUMMARY;
            end
            S_DUP_RD:
            begin
                state_next = S_DUP_CHK;
            end
            S_DUP_CHK:
            begin
                if (r_rd == cmd_reg.seq)
                begin
                    dup_next = 1'b1;
                end
                r_idx_next = r_idx_reg + 1'b1;
                state_next = (r_idx_reg + 1'b1 == r_fill_reg) ? S_RECV_WR : S_DUP_RD;
            end
            S_RECV_WR:
            begin
                if (!dup_reg)
                begin
                    r_we = 1'b1;
                    if (r_fill_reg == RF_W'(RECV_DEPTH))
                    begin
                        r_wa        = r_head_reg;
                        r_head_next = r_wrap({1'b0, r_head_reg} + (RA_W+1)'(1));
                    end
                    else
                    begin
                        r_fill_next = r_fill_reg + 1'b1;
                    end
                    latest_next = cmd_reg.seq;
                    if (cmd_reg.seq > remote_reg)
                    begin
                        remote_next = cmd_reg.seq;
                    end
                end
                r_idx_next = '0;
                bits_next  = '0;
                state_next = S_BITS_RD;
            end
            S_ACK_RD:
            begin
                if (p_idx_reg == p_fill_reg)
                begin
                    p_fill_next = p_wj_reg;
                    state_next  = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_ACK_CHK;
                end
            end
            S_ACK_CHK:
            begin
                p_idx_next = p_idx_reg + 1'b1;
                if (hit && nack_reg < AK_W'(rut_pkg::MAX_ACKS))
                begin
                    a_we      = 1'b1;
                    nack_next = nack_reg + 1'b1;
                    ackc_next = ackc_reg + 32'd1;
                    neg_next  = diff[36];
                    div_next  = diff[36] ? diff_neg[35:0] : diff[35:0];
                    rem_next  = '0;
                    dcnt_next = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    // keep entry, compacting toward the head
                    p_we = 1'b1;
                    p_wa = p_wrap({1'b0, p_head_reg} + (PA_W+1)'(p_wj_reg[PA_W-1:0]));
                    p_wd = p_rd;
                    p_wj_next  = p_wj_reg + 1'b1;
                    state_next = S_ACK_RD;
                end
            end
            S_DIV:
            begin
                div_next  = {div_reg[31:0], dstep[7:4]};
                rem_next  = dstep[3:0];
                dcnt_next = dcnt_reg + 4'd1;
                if (dcnt_reg == 4'd8)
                begin
                    state_next = S_RTT;
                end
            end
            S_RTT:
            begin
                if (!neg_reg)
                begin
                    rtt_next = (rsum[36:32] != '0) ? 32'hFFFF_FFFF : rsum[31:0];
                end
                else
                begin
                    rtt_next = ({4'b0000, rtt_reg} < div_reg) ? 32'd0 : rtt_reg - div_reg[31:0];
                end
                state_next = S_ACK_RD;
            end
            S_PRUNE_RD:
            begin
                r_ra = r_head_reg;
                state_next = (r_fill_reg == '0) ? S_EXP_RD : S_PRUNE_CHK;
            end
            S_PRUNE_CHK:
            begin
                if (r_rd < minseq)
                begin
                    r_head_next = r_wrap({1'b0, r_head_reg} + (RA_W+1)'(1));
                    r_fill_next = r_fill_reg - 1'b1;
                    state_next  = S_PRUNE_RD;
                end
                else
                begin
                    state_next = S_EXP_RD;
                end
            end
            S_EXP_RD:
            begin
                p_ra = p_head_reg;
                if (p_fill_reg == '0)
                begin
                    r_idx_next = '0;
                    bits_next  = '0;
                    state_next = S_BITS_RD;
                end
                else
                begin
                    state_next = S_EXP_CHK;
                end
            end
            S_EXP_CHK:
            begin
                if (age > {16'd0, rtt_max})
                begin
                    p_head_next = p_wrap({1'b0, p_head_reg} + (PA_W+1)'(1));
                    p_fill_next = p_fill_reg - 1'b1;
                    lost_next   = lost_reg + 32'd1;
                    state_next  = S_EXP_RD;
                end
                else
                begin
                    r_idx_next = '0;
                    bits_next  = '0;
                    state_next = S_BITS_RD;
                end
            end
            S_BITS_RD:
            begin
                state_next = (r_idx_reg == r_fill_reg) ? S_EMIT_RD : S_BITS_CHK;
            end
            S_BITS_CHK:
            begin
                if (r_rd < remote_reg && d_bits <= 32'(rut_pkg::ACK_WINDOW))
                begin
                    bits_next = bits_reg | (32'd1 << d_bits[4:0]);
                end
                r_idx_next = r_idx_reg + 1'b1;
                state_next = S_BITS_RD;
            end
            S_EMIT_RD:
            begin
                state_next = (emit_reg == nack_reg) ? S_SUMMARY : S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                done_next               = 1'b1;
                result_next.last        = 1'b0;
                result_next.acked_valid = 1'b1;
                result_next.acked_seq   = a_rd;
                emit_next  = emit_reg + 1'b1;
                state_next = S_EMIT_RD;
            end
            S_SUMMARY:
            begin
                done_next               = 1'b1;
                result_next.last        = 1'b1;
                result_next.acked_valid = 1'b0;
                result_next.acked_seq   = '0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            local_reg  <= '0;
            remote_reg <= '0;
            latest_reg <= '0;
            sent_reg   <= '0;
            recvc_reg  <= '0;
            lost_reg   <= '0;
            ackc_reg   <= '0;
            rtt_reg    <= '0;
            bits_reg   <= '0;
            p_head_reg <= '0;
            p_fill_reg <= '0;
            r_head_reg <= '0;
            r_fill_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            local_reg  <= local_next;
            remote_reg <= remote_next;
            latest_reg <= latest_next;
            sent_reg   <= sent_next;
            recvc_reg  <= recvc_next;
            lost_reg   <= lost_next;
            ackc_reg   <= ackc_next;
            rtt_reg    <= rtt_next;
            bits_reg   <= bits_next;
            p_head_reg <= p_head_next;
            p_fill_reg <= p_fill_next;
            r_head_reg <= r_head_next;
            r_fill_reg <= r_fill_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        p_idx_reg  <= p_idx_next;
        p_wj_reg   <= p_wj_next;
        r_idx_reg  <= r_idx_next;
        dup_reg    <= dup_next;
        nack_reg   <= nack_next;
        emit_reg   <= emit_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        dcnt_reg   <= dcnt_next;
        neg_reg    <= neg_next;
        result_reg <= result_next;
    end

    assign done           = done_reg;
    assign result         = result_reg;
    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.pend_fill = rut_pkg::FILL_W'(p_fill_reg);
    assign stat.recv_fill = rut_pkg::FILL_W'(r_fill_reg);
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for the reliable-UDP ack tracker: predictor, driver, monitor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import rut_pkg::*;

    localparam int PEND_CAP = 64;
    localparam int RECV_CAP = 64;
    localparam int SPAN     = 34;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_beat_t item = '0;
    logic done;
    out_beat_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    reliable_udp_ack_tracker_top i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of the tracker
    // ------------------------------------------------------------------
    logic [15:0] lim_ms;
    logic [31:0] nxt_local, top_remote, newest_recv, rtt_q4;
    logic [31:0] n_sent, n_recv, n_lost, n_acked;
    logic [31:0] pend_seq[$];
    logic [31:0] pend_stamp[$];
    logic [31:0] recv_seq[$];

    out_beat_t beats_due[$];     // expected result beats, oldest first
    in_beat_t  items_todo[$];    // beats waiting for the driver
    int errors = 0;
    int beats_seen = 0;
    int acks_seen = 0;
    logic sender_idle_ok = 1'b1;   // when 0, driver never idles
    logic hold = 1'b0;             // pauses driver when set
    logic [31:0] phase_lims[4] = '{32'd65535, 32'd1, 32'd500, 32'd1000};

    function automatic logic [31:0] recv_window_bits();
        logic [31:0] b;
        logic [31:0] d;
        b = '0;
        foreach (recv_seq[i])
            if (recv_seq[i] < top_remote)
            begin
                d = top_remote - 32'd1 - recv_seq[i];
                if (d <= 32'd31)
                    b[d[4:0]] = 1'b1;
            end
        return b;
    endfunction

    function automatic out_beat_t status_beat(logic lst, logic av, logic [31:0] s);
        out_beat_t o;
        o.last = lst;
        o.acked_valid = av;
        o.acked_seq = s;
        o.local_seq = nxt_local;
        o.remote_seq = top_remote;
        o.ack_bits = recv_window_bits();
        o.sent_count = n_sent;
        o.recv_count = n_recv;
        o.lost_count = n_lost;
        o.acked_count = n_acked;
        o.rtt_est = rtt_q4;
        return o;
    endfunction

    function automatic void smooth_rtt(logic [31:0] age);
        longint tgt, cur, nr;
        tgt = longint'(age) * 16;
        cur = longint'(rtt_q4);
        nr = cur + (tgt - cur) / 10;   // SV division truncates toward zero
        if (nr > 64'sh0FFFFFFFF)
            nr = 64'sh0FFFFFFFF;
        if (nr < 0)
            nr = 0;
        rtt_q4 = nr[31:0];
    endfunction

    // Apply one accepted beat and queue the result beats it causes.
    function automatic void track_beat(in_beat_t b);
        logic [31:0] hits[$];
        logic [31:0] d, s, minseq;
        logic dup, hit;
        int i;
        case (op_t'(b.action))
            OP_SEND:
            begin
                if (pend_seq.size() >= PEND_CAP)
                begin
                    pend_seq.delete(0);
                    pend_stamp.delete(0);
                    n_lost++;
                end
                pend_seq.insert(pend_seq.size(), nxt_local);
                pend_stamp.insert(pend_stamp.size(), b.now_ms);
                n_sent++;
                nxt_local++;
            end
            OP_RECV:
            begin
                n_recv++;
                dup = 1'b0;
                foreach (recv_seq[j])
                    if (recv_seq[j] == b.seq_in)
                        dup = 1'b1;
                if (!dup)
                begin
                    if (recv_seq.size() >= RECV_CAP)
                        recv_seq.delete(0);
                    recv_seq.insert(recv_seq.size(), b.seq_in);
                    newest_recv = b.seq_in;
                    if (b.seq_in > top_remote)
                        top_remote = b.seq_in;
                end
            end
            OP_ACK:
            begin
                i = 0;
                while (i < pend_seq.size())
                begin
                    s = pend_seq[i];
                    hit = (s == b.ack_seq);
                    if (!hit && s < b.ack_seq)
                    begin
                        d = b.ack_seq - 32'd1 - s;
                        if (d <= 32'd31)
                            hit = b.ack_bits_in[d[4:0]];
                    end
                    if (hit && hits.size() < MAX_ACKS)
                    begin
                        smooth_rtt(b.now_ms - pend_stamp[i]);
                        hits.insert(hits.size(), s);
                        n_acked++;
                        pend_seq.delete(i);
                        pend_stamp.delete(i);
                    end
                    else
                        i++;
                end
            end
            default:
            begin
                if (recv_seq.size() > 0)
                begin
                    minseq = (newest_recv > SPAN) ? newest_recv - SPAN : 32'd0;
                    while (recv_seq.size() > 0 && recv_seq[0] < minseq)
                        recv_seq.delete(0);
                end
                while (pend_seq.size() > 0 && (b.now_ms - pend_stamp[0]) > {16'd0, lim_ms})
                begin
                    pend_seq.delete(0);
                    pend_stamp.delete(0);
                    n_lost++;
                end
            end
        endcase
        // status is taken after the whole step, so build after the update
        foreach (hits[k])
            beats_due.insert(beats_due.size(), status_beat(1'b0, 1'b1, hits[k]));
        beats_due.insert(beats_due.size(), status_beat(1'b1, 1'b0, 32'd0));
    endfunction

    // ------------------------------------------------------------------
    // Driver: takes items_todo in order, holds start until the beat is taken
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                track_beat(item);
            if ((!start || !busy))
            begin
                if (!hold && items_todo.size() > 0
                    && (!sender_idle_ok || $urandom_range(99) >= 17))
                begin
                    start <= 1'b1;
                    item <= items_todo[0];
                    items_todo.delete(0);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe is one result beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && done)
        begin
            beats_seen++;
            if (result.acked_valid)
                acks_seen++;
            if (beats_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %p", $realtime,
                         result);
            end
            else
            begin
                want = beats_due[0];
                beats_due.delete(0);
                if (result !== want)
                begin
                    errors++;
                    $display("%0t: result mismatch, expected %p, actual %p", $realtime,
                             want, result);
                end
            end
        end
    end

    // Watchdog
    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] clock_ms = 32'd0;

    function automatic in_beat_t mk(op_t op, logic [31:0] now, logic [31:0] sq,
                                    logic [31:0] ak, logic [31:0] bits);
        in_beat_t b;
        b.action = op;
        b.now_ms = now;
        b.seq_in = sq;
        b.ack_seq = ak;
        b.ack_bits_in = bits;
        return b;
    endfunction

    function automatic void add_item(in_beat_t b);
        items_todo.insert(items_todo.size(), b);
    endfunction

    // wait until all queued beats are taken and all results are back
    task automatic drain();
        while (items_todo.size() > 0 || start || beats_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write(logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(REG_RTT_MAX) * 3'd4;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        lim_ms = v[15:0];
    endtask

    // random beat biased toward a live session around the current counters
    function automatic in_beat_t rand_beat();
        int r;
        logic [31:0] base;
        r = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(0, 300);
        if (r < 5)
            return mk(op_t'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        if (r < 35)
            return mk(OP_SEND, clock_ms, $urandom, $urandom, $urandom);
        if (r < 60)
        begin
            base = top_remote + 32'd8;
            return mk(OP_RECV, clock_ms, base - 32'($urandom_range(0, 45)), $urandom, $urandom);
        end
        if (r < 85)
            return mk(OP_ACK, clock_ms, $urandom, nxt_local - 32'($urandom_range(0, 6)),
                      $urandom);
        return mk(OP_TICK, clock_ms, $urandom, $urandom, $urandom);
    endfunction

    initial
    begin
        lim_ms = RTT_MAX_RESET;
        nxt_local = '0; top_remote = '0; newest_recv = '0; rtt_q4 = '0;
        n_sent = '0; n_recv = '0; n_lost = '0; n_acked = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each action's corner cases
        add_item(mk(OP_TICK, 32'd0, '0, '0, '0));          // tick on empty stores
        add_item(mk(OP_ACK, 32'd5, '0, '0, '1));           // ack with nothing pending
        add_item(mk(OP_SEND, 32'd0, '1, '1, '1));
        add_item(mk(OP_SEND, 32'd10, '0, '0, '0));
        add_item(mk(OP_SEND, 32'd20, '0, '0, '0));
        add_item(mk(OP_RECV, 32'd30, 32'd5, '0, '0));
        add_item(mk(OP_RECV, 32'd31, 32'd5, '0, '0));     // duplicate
        add_item(mk(OP_RECV, 32'd32, 32'd40, '0, '0));    // bits span edge
        add_item(mk(OP_RECV, 32'd33, 32'd8, '0, '0));
        add_item(mk(OP_RECV, 32'd33, 32'hFFFF_FFFF, '0, '0));
        add_item(mk(OP_ACK, 32'd400, '0, 32'd2, 32'h3));   // acks 2, 1, 0
        add_item(mk(OP_SEND, 32'hFFFF_FFF0, '0, '0, '0));
        add_item(mk(OP_ACK, 32'h0000_0010, '0, 32'd3, '0)); // wrapped age
        add_item(mk(OP_SEND, 32'd100, '0, '0, '0));
        add_item(mk(OP_TICK, 32'hFFFF_FFFF, '0, '0, '0));  // expiry + pruning
        for (int k = 0; k < 6; k++)
            add_item(mk(OP_SEND, 32'd50, '0, '0, '0));
        add_item(mk(OP_ACK, 32'd60, '0, 32'd40, 32'h8000_0000)); // bit 31 only
        drain();

        // 0 = nothing survives a nonzero age; also the small end
        apb_write(32'd0);
        add_item(mk(OP_SEND, 32'd70, '0, '0, '0));
        add_item(mk(OP_TICK, 32'd70, '0, '0, '0));
        add_item(mk(OP_TICK, 32'd71, '0, '0, '0));
        drain();

        // random phases over several limits; first phase never idles
        foreach (phase_lims[p])
        begin
            apb_write(phase_lims[p]);
            sender_idle_ok = (p != 0);
            for (int k = 0; k < 5; k++)
                add_item(rand_beat());
            drain();   // sender waits for every result before the next setting
        end
        // overflow both stores with a long send/receive burst, then one ack
        // that hits its own sequence and the 32 below it
        for (int k = 0; k < 66; k++)
        begin
            add_item(mk(OP_SEND, clock_ms, '0, '0, '0));
            add_item(mk(OP_RECV, clock_ms, 32'h1000 + 32'(k), '0, '0));
        end
        add_item(mk(OP_ACK, clock_ms, '0, nxt_local + 32'd65, '1));
        add_item(mk(OP_TICK, clock_ms + 32'd70000, '0, '0, '0));
        drain();

        $display("Covered %0d result beats, %0d of them acknowledgments, across %0d limits.",
                 beats_seen, acks_seen, 6);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/rut_pkg.sv
sv/rut_ram.sv
sv/rut_front.sv
sv/rut_engine.sv
sv/reliable_udp_ack_tracker_top.sv
tb/tb_top.sv
